@@ rtl/core/mip_pkg.sv @@
// Shared types and constants for the mobility identity element parser.
package mip_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       has_tag;
  } mip_in_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [2:0]  digit_count;
    logic        error;
    logic        last;
  } mip_out_t;

  localparam logic [3:0] KIND_TAG    = 4'd0;
  localparam logic [3:0] KIND_LENGTH = 4'd1;
  localparam logic [3:0] KIND_TYPE   = 4'd2;
  localparam logic [3:0] KIND_FMT    = 4'd3;
  localparam logic [3:0] KIND_MCC    = 4'd4;
  localparam logic [3:0] KIND_MNC    = 4'd5;
  localparam logic [3:0] KIND_ROUT   = 4'd6;
  localparam logic [3:0] KIND_SCHEME = 4'd7;
  localparam logic [3:0] KIND_KEY    = 4'd8;
  localparam logic [3:0] KIND_MSIN   = 4'd9;
  localparam logic [3:0] KIND_REGION = 4'd10;
  localparam logic [3:0] KIND_SET    = 4'd11;
  localparam logic [3:0] KIND_PTR    = 4'd12;
  localparam logic [3:0] KIND_TMSI   = 4'd13;
  localparam logic [3:0] KIND_END    = 4'd14;

  localparam logic [2:0] ID_SUCI  = 3'd1;
  localparam logic [2:0] ID_GUTI  = 3'd2;
  localparam logic [2:0] ID_STMSI = 3'd4;
  localparam logic [2:0] FMT_IMSI = 3'd0;

  localparam logic [3:0] NIB_F = 4'hF;

endpackage

@@ rtl/core/mip_decode.sv @@
// Front end: per-octet phase tracking and field decode.
module mip_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mip_pkg::mip_in_t  in_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mip_pkg::mip_out_t res_data_o
);
  import mip_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_TYPE, PH_PLMN1, PH_PLMN2, PH_PLMN3,
    PH_ROUT1, PH_ROUT2, PH_SCHEME, PH_KEY, PH_MSIN, PH_REGION, PH_SET_HI,
    PH_SET_LO, PH_TMSI0, PH_TMSI1, PH_TMSI2, PH_TMSI3, PH_SKIP_OK, PH_SKIP_ERR
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] left_q, left_d;
  logic [2:0]  idt_q, idt_d;
  logic [9:0]  cc_q, cc_d;
  logic [3:0]  net_q, net_d;
  logic [7:0]  lenh_q, lenh_d;
  logic [7:0]  rout_q, rout_d;
  logic [7:0]  seth_q, seth_d;
  logic [31:0] tmsi_q, tmsi_d;
  logic        derr_q, derr_d;

  logic        emit;
  mip_out_t    res;
  logic        acc;

  function automatic logic [3:0] clamp(input logic [3:0] d);
    return (d <= 4'd9) ? d : 4'd9;
  endfunction

  logic [7:0] b;
  logic [3:0] lo, hi;
  logic       fin;
  logic [3:0] rd [4];
  logic       stop;
  logic [13:0] rv;

  assign b  = in_data_i.data_byte;
  assign lo = b[3:0];
  assign hi = b[7:4];
  assign in_ready_o = res_ready_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q; left_d = left_q; idt_d = idt_q; cc_d = cc_q;
    net_d = net_q; lenh_d = lenh_q; rout_d = rout_q; seth_d = seth_q;
    tmsi_d = tmsi_q; derr_d = derr_q;
    emit = 1'b0;
    res = '0;
    fin = (left_q <= 16'd1);
    rd[0] = rout_q[3:0]; rd[1] = rout_q[7:4]; rd[2] = lo; rd[3] = hi;
    stop = 1'b0; rv = '0;
    if (in_data_i.start_req) begin
      left_d = '0; idt_d = '0; cc_d = '0; net_d = '0; rout_d = '0;
      seth_d = '0; tmsi_d = '0; derr_d = 1'b0;
      if (in_data_i.has_tag) begin
        lenh_d = '0; phase_d = PH_LEN_HI; emit = 1'b1;
        res.kind = KIND_TAG; res.value = {24'd0, b};
      end else begin
        lenh_d = b; phase_d = PH_LEN_LO;
      end
    end else if (phase_q == PH_IDLE) begin
    end else if (phase_q == PH_LEN_HI) begin
      lenh_d = b; phase_d = PH_LEN_LO;
    end else if (phase_q == PH_LEN_LO) begin
      left_d = {lenh_q, b};
      emit = 1'b1;
      res.kind = KIND_LENGTH; res.value = {16'd0, lenh_q, b};
      if ({lenh_q, b} == 16'd0) begin
        phase_d = PH_IDLE; res.error = 1'b1; res.last = 1'b1;
      end else phase_d = PH_TYPE;
    end else begin
      left_d = left_q - ((left_q != 16'd0) ? 16'd1 : 16'd0);
      case (phase_q)
        PH_TYPE: begin
          idt_d = b[2:0]; emit = 1'b1;
          if (b[2:0] == ID_SUCI) begin
            res.kind = KIND_FMT; res.value = {29'd0, b[6:4]};
            if (b[6:4] == FMT_IMSI) phase_d = PH_PLMN1;
            else begin res.error = 1'b1; phase_d = PH_SKIP_ERR; end
          end else begin
            res.kind = KIND_TYPE; res.value = {29'd0, b[2:0]};
            if (b[2:0] == ID_GUTI) phase_d = PH_PLMN1;
            else if (b[2:0] == ID_STMSI) phase_d = PH_SET_HI;
            else begin res.error = 1'b1; phase_d = PH_SKIP_ERR; end
          end
        end
        PH_PLMN1: begin
          derr_d = (lo > 4'd9) || (hi > 4'd9);
          cc_d = {6'd0, clamp(lo)} * 10'd100 + {6'd0, clamp(hi)} * 10'd10;
          phase_d = PH_PLMN2;
        end
        PH_PLMN2: begin
          emit = 1'b1; res.kind = KIND_MCC;
          res.value = {22'd0, cc_q + {6'd0, clamp(lo)}};
          res.error = derr_q || (lo > 4'd9);
          net_d = hi; phase_d = PH_PLMN3;
        end
        PH_PLMN3: begin
          emit = 1'b1; res.kind = KIND_MNC;
          if (net_q == NIB_F) begin
            res.value = {22'd0, {6'd0, clamp(lo)} * 10'd10 + {6'd0, clamp(hi)}};
            res.digit_count = 3'd2;
            res.error = (lo > 4'd9) || (hi > 4'd9);
          end else begin
            res.value = {22'd0, {6'd0, clamp(lo)} * 10'd100 + {6'd0, clamp(hi)} * 10'd10
                         + {6'd0, clamp(net_q)}};
            res.digit_count = 3'd3;
            res.error = (lo > 4'd9) || (hi > 4'd9) || (net_q > 4'd9);
          end
          phase_d = (idt_q == ID_SUCI) ? PH_ROUT1 : PH_REGION;
        end
        PH_ROUT1: begin rout_d = b; phase_d = PH_ROUT2; end
        PH_ROUT2: begin
          emit = 1'b1; res.kind = KIND_ROUT;
          if (!(rd[0] == 4'd0 && rd[1] == NIB_F && rd[2] == NIB_F && rd[3] == NIB_F)) begin
            for (int i = 0; i < 4; i++) begin
              if (!stop) begin
                if (rd[i] <= 4'd9) begin
                  rv = 14'(rv * 4'd10) + {10'd0, rd[i]};
                  res.digit_count = res.digit_count + 3'd1;
                end else if (rd[i] == NIB_F) stop = 1'b1;
                else res.error = 1'b1;
              end
            end
          end
          res.value = {18'd0, rv};
          phase_d = PH_SCHEME;
        end
        PH_SCHEME: begin
          emit = 1'b1; res.kind = KIND_SCHEME; res.value = {28'd0, lo}; phase_d = PH_KEY;
        end
        PH_KEY: begin
          emit = 1'b1; res.kind = KIND_KEY; res.value = {24'd0, b}; phase_d = PH_MSIN;
        end
        PH_MSIN: begin
          emit = 1'b1; res.kind = KIND_MSIN; res.value = {24'd0, b};
          res.digit_count = (hi == NIB_F) ? 3'd1 : 3'd2;
          res.error = (lo > 4'd9) || (hi != NIB_F && hi > 4'd9);
        end
        PH_REGION: begin
          emit = 1'b1; res.kind = KIND_REGION; res.value = {24'd0, b}; phase_d = PH_SET_HI;
        end
        PH_SET_HI: begin seth_d = b; phase_d = PH_SET_LO; end
        PH_SET_LO: begin
          emit = 1'b1; res.kind = KIND_SET; res.value = {22'd0, seth_q, b[7:6]};
          seth_d = {2'b00, b[5:0]}; phase_d = PH_TMSI0;
        end
        PH_TMSI0: begin
          emit = 1'b1; res.kind = KIND_PTR; res.value = {24'd0, seth_q};
          tmsi_d = {24'd0, b}; phase_d = PH_TMSI1;
        end
        PH_TMSI1: begin tmsi_d = {tmsi_q[23:0], b}; phase_d = PH_TMSI2; end
        PH_TMSI2: begin tmsi_d = {tmsi_q[23:0], b}; phase_d = PH_TMSI3; end
        PH_TMSI3: begin
          tmsi_d = {tmsi_q[23:0], b}; emit = 1'b1; res.kind = KIND_TMSI;
          res.value = {tmsi_q[23:0], b}; phase_d = PH_SKIP_OK;
        end
        default: ;
      endcase
      if (fin) begin
        if (!emit) begin res = '0; res.kind = KIND_END; end
        emit = 1'b1;
        if (phase_d != PH_SKIP_OK && phase_d != PH_MSIN) res.error = 1'b1;
        res.last = 1'b1;
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; left_q <= '0; idt_q <= '0; cc_q <= '0; net_q <= '0;
      lenh_q <= '0; rout_q <= '0; seth_q <= '0; tmsi_q <= '0; derr_q <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d; left_q <= left_d; idt_q <= idt_d; cc_q <= cc_d;
      net_q <= net_d; lenh_q <= lenh_d; rout_q <= rout_d; seth_q <= seth_d;
      tmsi_q <= tmsi_d; derr_q <= derr_d;
    end
  end

  assign res_valid_o = acc && emit;
  assign res_data_o  = res;

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && phase_q == PH_IDLE && !in_data_i.start_req) |-> !res_valid_o)
    else $error("idle octet produced a result");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_data_o.last) |=> (phase_q == PH_IDLE))
    else $error("last result without return to idle");
  a_tag_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.start_req && in_data_i.has_tag) |=> (phase_q == PH_LEN_HI))
    else $error("tag not followed by length");
endmodule

@@ rtl/core/mip_queue.sv @@
// Back end: two-entry result queue between decode and the output port.
module mip_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  mip_pkg::mip_out_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output mip_pkg::mip_out_t rd_data_o
);
  import mip_pkg::*;

  mip_out_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !rd) |=> (cnt_q == 2'd2))
    else $error("queue count lost an entry");
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count beyond depth");
  a_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q))
    else $error("queue pointers disagree with count");
endmodule

@@ rtl/core/mobility_identity_ie_parser_core.sv @@
// Top level of the mobility identity element parser.
// A result is decoded combinationally and is written to the result queue when its octet is accepted.
// The parser takes one octet per cycle while the result queue has room; decode is a combinational phase step.
// A two-entry result queue lets the input keep flowing while the output stalls, until the queue is full.
// Reset (rst_ni low, asynchronous) returns the parser to idle and empties the queue.
module mobility_identity_ie_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mip_pkg::mip_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mip_pkg::mip_out_t out_data_o
);
  import mip_pkg::*;

  logic     rv, rr;
  mip_out_t rdat;

  mip_decode u_dec (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .res_valid_o(rv), .res_ready_i(rr), .res_data_o(rdat)
  );

  mip_queue u_q (
    .clk_i, .rst_ni, .wr_valid_i(rv), .wr_ready_o(rr), .wr_data_i(rdat),
    .rd_valid_o(out_valid_o), .rd_ready_i(out_ready_i), .rd_data_o(out_data_o)
  );
endmodule

@@ tb/tb_mobility_identity_ie_parser_core.sv @@
// Testbench for the mobility identity element parser: directed and random elements.
`timescale 1ns / 1ps
module tb_mobility_identity_ie_parser_core;
  import mip_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LEN_HI, S_LEN_LO, S_TYPE, S_PLMN1, S_PLMN2, S_PLMN3, S_ROUT1, S_ROUT2,
    S_SCHEME, S_KEY, S_MSIN, S_REGION, S_SET_HI, S_SET_LO, S_TMSI0, S_TMSI1, S_TMSI2,
    S_TMSI3, S_SKIP_OK, S_SKIP_ERR
  } parse_phase_e;

  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  mip_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  mip_out_t out_data_o;

  mobility_identity_ie_parser_core u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  parse_phase_e ph;
  logic [15:0] left_cnt;
  logic [2:0]  id_type;
  logic [9:0]  mcc_acc;
  logic [3:0]  mnc_hold;
  logic [7:0]  len_hi;
  logic [7:0]  rout_lo;
  logic [7:0]  set_hi;
  logic [31:0] tmsi_acc;
  logic        mcc_bad;

  mip_out_t field_q[$];
  int n_sent, n_checked, n_mism, n_cycles;
  int burst_left;

  function automatic logic [31:0] dg(logic [3:0] d);
    return (d <= 9) ? 32'(d) : 32'd9;
  endfunction

  task automatic clear_parse();
    ph = S_IDLE; left_cnt = '0; id_type = '0; mcc_acc = '0; mnc_hold = '0;
    len_hi = '0; rout_lo = '0; set_hi = '0; tmsi_acc = '0; mcc_bad = 1'b0;
  endtask

  task automatic decode_octet(mip_in_t it);
    logic [7:0] b;
    logic [3:0] lo, hi;
    logic [3:0] d[4];
    int kd;
    logic [31:0] v;
    logic [2:0] c;
    logic er, fin, stop;
    mip_out_t r;
    b = it.data_byte; lo = b[3:0]; hi = b[7:4];
    kd = -1; v = '0; c = '0; er = 1'b0;
    if (it.start_req) begin
      clear_parse();
      if (it.has_tag) begin
        ph = S_LEN_HI;
        r = '{KIND_TAG, 32'(b), 3'd0, 1'b0, 1'b0};
        field_q.push_back(r);
      end else begin
        len_hi = b; ph = S_LEN_LO;
      end
      return;
    end
    if (ph == S_IDLE) return;
    if (ph == S_LEN_HI) begin len_hi = b; ph = S_LEN_LO; return; end
    if (ph == S_LEN_LO) begin
      left_cnt = {len_hi, b};
      if (left_cnt == 0) begin
        ph = S_IDLE;
        r = '{KIND_LENGTH, 32'd0, 3'd0, 1'b1, 1'b1};
      end else begin
        ph = S_TYPE;
        r = '{KIND_LENGTH, 32'(left_cnt), 3'd0, 1'b0, 1'b0};
      end
      field_q.push_back(r);
      return;
    end
    fin = (left_cnt <= 1);
    if (left_cnt != 0) left_cnt = left_cnt - 1;
    case (ph)
      S_TYPE: begin
        id_type = b[2:0];
        if (id_type == ID_SUCI) begin
          kd = KIND_FMT; v = 32'(b[6:4]);
          if (b[6:4] == FMT_IMSI) ph = S_PLMN1; else begin er = 1; ph = S_SKIP_ERR; end
        end else begin
          kd = KIND_TYPE; v = 32'(id_type);
          if (id_type == ID_GUTI) ph = S_PLMN1;
          else if (id_type == ID_STMSI) ph = S_SET_HI;
          else begin er = 1; ph = S_SKIP_ERR; end
        end
      end
      S_PLMN1: begin
        mcc_bad = (lo > 9) || (hi > 9);
        mcc_acc = 10'(dg(lo) * 100 + dg(hi) * 10);
        ph = S_PLMN2;
      end
      S_PLMN2: begin
        kd = KIND_MCC; v = 32'(mcc_acc) + dg(lo);
        er = mcc_bad || (lo > 9); mnc_hold = hi; ph = S_PLMN3;
      end
      S_PLMN3: begin
        kd = KIND_MNC;
        if (mnc_hold == NIB_F) begin
          v = dg(lo) * 10 + dg(hi); c = 3'd2; er = (lo > 9) || (hi > 9);
        end else begin
          v = dg(lo) * 100 + dg(hi) * 10 + dg(mnc_hold); c = 3'd3;
          er = (lo > 9) || (hi > 9) || (mnc_hold > 9);
        end
        ph = (id_type == ID_SUCI) ? S_ROUT1 : S_REGION;
      end
      S_ROUT1: begin rout_lo = b; ph = S_ROUT2; end
      S_ROUT2: begin
        d[0] = rout_lo[3:0]; d[1] = rout_lo[7:4]; d[2] = lo; d[3] = hi;
        kd = KIND_ROUT; stop = 1'b0;
        // 0 then three F fillers means no indicator
        if (!(d[0] == 0 && d[1] == NIB_F && d[2] == NIB_F && d[3] == NIB_F))
          for (int i = 0; i < 4; i++)
            if (!stop) begin
              if (d[i] <= 9) begin v = v * 10 + 32'(d[i]); c = c + 3'd1; end
              else if (d[i] == NIB_F) stop = 1'b1;
              else er = 1'b1;
            end
        ph = S_SCHEME;
      end
      S_SCHEME: begin kd = KIND_SCHEME; v = 32'(lo); ph = S_KEY; end
      S_KEY: begin kd = KIND_KEY; v = 32'(b); ph = S_MSIN; end
      S_MSIN: begin
        kd = KIND_MSIN; v = 32'(b);
        c = (hi == NIB_F) ? 3'd1 : 3'd2;
        er = (lo > 9) || (hi != NIB_F && hi > 9);
      end
      S_REGION: begin kd = KIND_REGION; v = 32'(b); ph = S_SET_HI; end
      S_SET_HI: begin set_hi = b; ph = S_SET_LO; end
      S_SET_LO: begin
        kd = KIND_SET; v = {22'd0, set_hi, b[7:6]};
        set_hi = {2'b00, b[5:0]}; ph = S_TMSI0;
      end
      S_TMSI0: begin kd = KIND_PTR; v = 32'(set_hi); tmsi_acc = 32'(b); ph = S_TMSI1; end
      S_TMSI1, S_TMSI2: begin
        tmsi_acc = {tmsi_acc[23:0], b};
        ph = parse_phase_e'(ph + 1);
      end
      S_TMSI3: begin
        tmsi_acc = {tmsi_acc[23:0], b}; kd = KIND_TMSI; v = tmsi_acc; ph = S_SKIP_OK;
      end
      default: ;
    endcase
    if (fin) begin
      if (kd < 0) begin kd = KIND_END; v = '0; c = '0; end
      if (ph != S_SKIP_OK && ph != S_MSIN) er = 1'b1;
      ph = S_IDLE;
      r = '{4'(kd), v, c, er, 1'b1};
      field_q.push_back(r);
    end else if (kd >= 0) begin
      r = '{4'(kd), v, c, er, 1'b0};
      field_q.push_back(r);
    end
  endtask

  // one octet: random gap between bursts, held until accepted
  task automatic send_octet(logic [7:0] b, logic st, logic tg);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_data_i <= '{b, st, tg};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_octet('{b, st, tg});
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_element(bit tg, logic [7:0] tagb, logic [15:0] len, logic [7:0] body[$]);
    if (tg) begin
      send_octet(tagb, 1'b1, 1'b1);
      send_octet(len[15:8], 1'b0, 1'b0);
    end else send_octet(len[15:8], 1'b1, 1'b0);
    send_octet(len[7:0], 1'b0, 1'b0);
    foreach (body[i]) send_octet(body[i], 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] bcd_pair(bit noisy);
    logic [3:0] a, b;
    a = $urandom_range(0, 9); b = $urandom_range(0, 9);
    if (noisy && $urandom_range(0, 5) == 0) a = $urandom;
    if (noisy && $urandom_range(0, 5) == 0) b = $urandom;
    return {b, a};
  endfunction

  function automatic logic [3:0] bcd_lo(bit noisy);
    logic [7:0] p;
    p = bcd_pair(noisy);
    return p[3:0];
  endfunction

  // body of a random type, mostly supported and well formed, with occasional corruption
  function automatic void build_body(ref logic [7:0] body[$]);
    int sel, n;
    bit noisy;
    body = {};
    sel = $urandom_range(0, 9);
    noisy = ($urandom_range(0, 3) == 0);
    if (sel < 4) begin
      body.push_back({1'b0, noisy ? 3'($urandom) : FMT_IMSI, 1'b0, ID_SUCI}
                     | 8'($urandom_range(0,1) << 7));
      body.push_back(bcd_pair(noisy));
      body.push_back($urandom_range(0, 1) ? {NIB_F, bcd_lo(noisy)} : bcd_pair(noisy));
      body.push_back(bcd_pair(noisy));
      case ($urandom_range(0, 3))
        0: begin body.push_back(8'hF0); body.push_back(8'hFF); end
        1: begin body.push_back(bcd_pair(noisy)); body.push_back({NIB_F, bcd_lo(0)}); end
        default: begin body.push_back(8'($urandom)); body.push_back(8'($urandom)); end
      endcase
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      n = $urandom_range(0, 6);
      repeat (n) body.push_back($urandom_range(0, 3) == 0 ? {NIB_F, bcd_lo(0)} : bcd_pair(noisy));
    end else if (sel < 7) begin
      body.push_back({5'($urandom), ID_GUTI});
      body.push_back(bcd_pair(noisy));
      body.push_back($urandom_range(0, 1) ? {NIB_F, bcd_lo(noisy)} : bcd_pair(noisy));
      body.push_back(bcd_pair(noisy));
      repeat (7) body.push_back(8'($urandom));
    end else if (sel < 9) begin
      body.push_back({5'($urandom), ID_STMSI});
      repeat (6) body.push_back(8'($urandom));
    end else begin
      body.push_back(8'($urandom));
      repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
    end
    // shorten or lengthen now and then
    if ($urandom_range(0, 7) == 0 && body.size() > 1)
      repeat ($urandom_range(1, body.size() - 1)) void'(body.pop_back());
    else if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
  endfunction

  // receiver stalls in a slowly changing pattern
  int stall_mode;
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 1) != 0);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    mip_out_t want;
    n_cycles <= n_cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (field_q.size() == 0) begin
        n_mism++;
        if (n_mism <= 10) $display("unexpected item kind=%0d value=%0h", out_data_o.kind,
                                   out_data_o.value);
      end else begin
        want = field_q.pop_front();
        n_checked++;
        if (out_data_o !== want) begin
          n_mism++;
          if (n_mism <= 10)
            $display("mismatch: exp k=%0d v=%0h c=%0d e=%0b l=%0b got k=%0d v=%0h c=%0d e=%0b l=%0b",
                     want.kind, want.value, want.digit_count, want.error, want.last,
                     out_data_o.kind, out_data_o.value, out_data_o.digit_count,
                     out_data_o.error, out_data_o.last);
        end
      end
    end
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [7:0] bd[$];
    // SUCI IMSI, 3-digit mnc, no routing indicator
    bd = {8'h01, 8'h21, 8'h43, 8'h65, 8'hF0, 8'hFF, 8'h0A, 8'h00, 8'h21, 8'hF3};
    send_element(1, 8'h77, 16'(bd.size()), bd);
    // SUCI with 2-digit mnc, non-BCD digits, full routing indicator
    bd = {8'h81, 8'hA9, 8'hF9, 8'hCB, 8'h21, 8'h43, 8'hFF, 8'hFF, 8'hEE};
    send_element(0, 8'h00, 16'(bd.size()), bd);
    // unsupported SUPI format
    bd = {8'h71, 8'h00, 8'hFF};
    send_element(1, 8'hFF, 16'(bd.size()), bd);
    // GUTI, extremes
    bd = {8'hF2, 8'h99, 8'hF9, 8'h99, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_element(0, 8'h00, 16'(bd.size()), bd);
    // S-TMSI exact, then zero length
    bd = {8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_element(0, 8'h00, 16'(bd.size()), bd);
    bd = {};
    send_element(1, 8'h00, 16'd0, bd);
    // too short GUTI, unknown type, stray octet while idle
    bd = {8'h02, 8'h21};
    send_element(0, 8'h00, 16'd2, bd);
    send_octet(8'hAA, 1'b0, 1'b1);
    bd = {8'h03, 8'h55};
    send_element(0, 8'h00, 16'hFF02, bd);
    // restart in mid element
    send_octet(8'h00, 1'b1, 1'b0);
    send_octet(8'h05, 1'b0, 1'b0);
    send_octet(8'h04, 1'b0, 1'b0);
  endtask

  task automatic test_random();
    logic [7:0] bd[$];
    while (n_sent < 1950) begin
      if ($urandom_range(0, 19) == 0) begin
        send_octet(8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        build_body(bd);
        send_element($urandom_range(0, 1), 8'($urandom),
                     $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'(bd.size()), bd);
      end
    end
    // close any long element
    bd = {8'h04};
    send_element(0, 8'h00, 16'd1, bd);
  endtask

  initial begin
    n_sent = 0; n_checked = 0; n_mism = 0; n_cycles = 0; burst_left = 0; stall_mode = 0;
    clear_parse();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    in_valid_i <= 1'b0;
    while (field_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("sent %0d octets, checked %0d fields, %0d mismatches", n_sent, n_checked, n_mism);
    if (n_mism == 0 && field_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/mip_pkg.sv
rtl/core/mip_decode.sv
rtl/core/mip_queue.sv
rtl/core/mobility_identity_ie_parser_core.sv
tb/tb_mobility_identity_ie_parser_core.sv
